// ===== sv/tct_pkg.sv =====
package tct_pkg;

    // Widths fixed by the word formats.
    localparam int BYTE_W    = 8;
    localparam int ACT_W     = 3;
    localparam int CFG_IDX_W = 2;

    // Default width of the column counter.
    localparam int COLUMN_BITS_DEF = 8;

    // Action codes of an input word.
    localparam logic [ACT_W-1:0] ACT_CHAR    = 3'd0;
    localparam logic [ACT_W-1:0] ACT_TAB     = 3'd1;
    localparam logic [ACT_W-1:0] ACT_SKIP    = 3'd2;
    localparam logic [ACT_W-1:0] ACT_COMMA   = 3'd3;
    localparam logic [ACT_W-1:0] ACT_NEWLINE = 3'd4;
    localparam logic [ACT_W-1:0] ACT_FIT     = 3'd5;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_LINE_WIDTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ZONE_WIDTH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LAST_ZONE  = 2'd2;

    // Configuration reset values and the smallest nonzero line width.
    localparam logic [BYTE_W-1:0] LINE_WIDTH_RST = 8'd72;
    localparam logic [BYTE_W-1:0] ZONE_WIDTH_RST = 8'd14;
    localparam logic [BYTE_W-1:0] LAST_ZONE_RST  = 8'd56;
    localparam logic [BYTE_W-1:0] LINE_WIDTH_MIN = 8'd16;

    // Character codes.
    localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
    localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
    localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_REM,
        ST_CR,
        ST_LF,
        ST_TOK,
        ST_SPACE,
        ST_FLUSH
    } t_state;

    // Request from the sequencer to the run packer: one run of a character,
    // or a flush that closes the current input word.
    typedef struct packed {
        logic              valid;
        logic              flush;
        logic [BYTE_W-1:0] ch;
        logic [BYTE_W-1:0] cnt;
        logic              chan;
    } t_tok_req;

endpackage

// ===== sv/tct_if.sv =====
// Input channel: one character or layout command per word.
interface tct_in_if import tct_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [ACT_W-1:0]  action;
    logic [BYTE_W-1:0] value;
    logic              to_channel;
    logic              quiet;
    logic              error_pending;

    modport source (
        output valid, action, value, to_channel, quiet, error_pending,
        input  ready
    );
    modport sink (
        input  valid, action, value, to_channel, quiet, error_pending,
        output ready
    );
endinterface

// Output channel: one run-length character word per transfer.
interface tct_out_if import tct_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] out_char;
    logic [BYTE_W-1:0] repeat_res;
    logic              on_channel;
    logic              last;

    modport source (
        output valid, out_char, repeat_res, on_channel, last,
        input  ready
    );
    modport sink (
        input  valid, out_char, repeat_res, on_channel, last,
        output ready
    );
endinterface

// ===== sv/tct_rem_unit.sv =====
// Restoring remainder unit: one dividend bit per cycle, MSB first.
module tct_rem_unit import tct_pkg::*; #(
    parameter int COLUMN_BITS = COLUMN_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    input  logic [COLUMN_BITS-1:0] i_dividend,
    input  logic [BYTE_W-1:0]      i_divisor,
    output logic                   o_busy,
    output logic [BYTE_W-1:0]      o_rem
);

    localparam int CNT_W = $clog2(COLUMN_BITS + 1);

    logic [CNT_W-1:0]       r_cnt;
    logic [CNT_W-1:0]       n_cnt;
    logic [BYTE_W-1:0]      r_acc;
    logic [BYTE_W-1:0]      n_acc;
    logic [COLUMN_BITS-1:0] r_shift;
    logic [COLUMN_BITS-1:0] n_shift;
    logic [BYTE_W:0]        trial;
    logic [BYTE_W:0]        diff;

    // One trial subtraction per step.
    always_comb begin
        trial = {r_acc, r_shift[COLUMN_BITS-1]};
        diff  = trial - {1'b0, i_divisor};
    end

    // Step control.
    always_comb begin
        n_cnt   = r_cnt;
        n_acc   = r_acc;
        n_shift = r_shift;
        if (i_start) begin
            n_cnt   = CNT_W'(COLUMN_BITS);
            n_acc   = '0;
            n_shift = i_dividend;
        end else if (r_cnt != '0) begin
            n_cnt   = r_cnt - 1'b1;
            n_shift = {r_shift[COLUMN_BITS-2:0], 1'b0};
            if (trial >= {1'b0, i_divisor}) begin
                n_acc = diff[BYTE_W-1:0];
            end else begin
                n_acc = trial[BYTE_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc   <= n_acc;
        r_shift <= n_shift;
    end

    assign o_busy = (r_cnt != '0);
    assign o_rem  = r_acc;

endmodule

// ===== sv/tct_packer.sv =====
// Run packer: holds the newest run so that equal runs merge and the final
// word of an input can carry the last flag, then feeds the output register.
module tct_packer import tct_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_tok_req i_req,
    output logic     o_taken,
    tct_out_if.source o_out
);

    logic              r_pend_v;
    logic              n_pend_v;
    logic [BYTE_W-1:0] r_pend_ch;
    logic [BYTE_W-1:0] n_pend_ch;
    logic [BYTE_W-1:0] r_pend_cnt;
    logic [BYTE_W-1:0] n_pend_cnt;
    logic              r_pend_chan;
    logic              n_pend_chan;

    logic              r_out_v;
    logic              n_out_v;
    logic [BYTE_W-1:0] r_out_ch;
    logic [BYTE_W-1:0] n_out_ch;
    logic [BYTE_W-1:0] r_out_cnt;
    logic [BYTE_W-1:0] n_out_cnt;
    logic              r_out_chan;
    logic              n_out_chan;
    logic              r_out_last;
    logic              n_out_last;

    logic out_free;
    logic merge;

    // Handshake with the sequencer.
    always_comb begin
        out_free = !r_out_v || o_out.ready;
        merge    = r_pend_v && (r_pend_ch == i_req.ch) && (r_pend_chan == i_req.chan);
        if (i_req.valid) begin
            o_taken = !r_pend_v || merge || out_free;
        end else if (i_req.flush) begin
            o_taken = !r_pend_v || out_free;
        end else begin
            o_taken = 1'b0;
        end
    end

    // Pending run and output register updates.
    always_comb begin
        n_pend_v    = r_pend_v;
        n_pend_ch   = r_pend_ch;
        n_pend_cnt  = r_pend_cnt;
        n_pend_chan = r_pend_chan;
        n_out_v     = r_out_v && !o_out.ready;
        n_out_ch    = r_out_ch;
        n_out_cnt   = r_out_cnt;
        n_out_chan  = r_out_chan;
        n_out_last  = r_out_last;
        if (i_req.valid && o_taken) begin
            if (merge) begin
                n_pend_cnt = r_pend_cnt + i_req.cnt;
            end else begin
                if (r_pend_v) begin
                    n_out_v    = 1'b1;
                    n_out_ch   = r_pend_ch;
                    n_out_cnt  = r_pend_cnt;
                    n_out_chan = r_pend_chan;
                    n_out_last = 1'b0;
                end
                n_pend_v    = 1'b1;
                n_pend_ch   = i_req.ch;
                n_pend_cnt  = i_req.cnt;
                n_pend_chan = i_req.chan;
            end
        end else if (i_req.flush && o_taken && r_pend_v) begin
            n_out_v    = 1'b1;
            n_out_ch   = r_pend_ch;
            n_out_cnt  = r_pend_cnt;
            n_out_chan = r_pend_chan;
            n_out_last = 1'b1;
            n_pend_v   = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_v <= 1'b0;
            r_out_v  <= 1'b0;
        end else begin
            r_pend_v <= n_pend_v;
            r_out_v  <= n_out_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend_ch   <= n_pend_ch;
        r_pend_cnt  <= n_pend_cnt;
        r_pend_chan <= n_pend_chan;
        r_out_ch    <= n_out_ch;
        r_out_cnt   <= n_out_cnt;
        r_out_chan  <= n_out_chan;
        r_out_last  <= n_out_last;
    end

    assign o_out.valid      = r_out_v;
    assign o_out.out_char   = r_out_ch;
    assign o_out.repeat_res = r_out_cnt;
    assign o_out.on_channel = r_out_chan;
    assign o_out.last       = r_out_last;

endmodule

// ===== sv/text_column_tracker_unit.sv =====
// Text column tracker.
// The input channel takes one word per character or layout command (char,
// tab to column, skip spaces, comma zone, newline, number fit check). The
// output channel gives run-length words: a character, its repeat count, the
// sink it is bound for and a last flag on the final word of each input.
// An input that produces nothing gives no output word at all.
// Configuration is written through a plain write port (enable, index, data);
// the user must write it only while the block is idle; the block does not enforce it.
// One input is handled at a time and ready stays low meanwhile. A plain
// character goes through the token and flush states, after a carriage
// return and line feed when it wraps the line. A comma before the last
// zone first runs the remainder unit, then issues spaces up to the zone
// boundary. Space runs are issued one chunk per cycle while the packer
// takes them, a chunk ending at a line wrap, a zone boundary or a column
// rollover; each wrap adds a carriage return and line feed. Reset clears
// the column and restores the default line width, zone width and last
// zone start. A stalled receiver holds the output register and the
// sequencer waits; no word is lost.
module text_column_tracker_unit import tct_pkg::*; #(
    parameter int COLUMN_BITS = COLUMN_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [BYTE_W-1:0]    i_cfg_data,
    tct_in_if.sink               i_in,
    tct_out_if.source            o_out
);

    // Configuration registers.
    logic [BYTE_W-1:0] r_line_width;
    logic [BYTE_W-1:0] n_line_width;
    logic [BYTE_W-1:0] r_zone_width;
    logic [BYTE_W-1:0] n_zone_width;
    logic [BYTE_W-1:0] r_last_zone;
    logic [BYTE_W-1:0] n_last_zone;

    // Sequencer state.
    t_state                 r_state;
    t_state                 n_state;
    logic [COLUMN_BITS-1:0] r_col;
    logic [COLUMN_BITS-1:0] n_col;
    logic [BYTE_W-1:0]      r_rem;
    logic [BYTE_W-1:0]      n_rem;
    logic [BYTE_W-1:0]      r_left;
    logic [BYTE_W-1:0]      n_left;
    logic [BYTE_W-1:0]      r_tok_ch;
    logic [BYTE_W-1:0]      n_tok_ch;
    logic [BYTE_W-1:0]      r_tok_cnt;
    logic [BYTE_W-1:0]      n_tok_cnt;
    logic                   r_tok_adv;
    logic                   n_tok_adv;
    logic                   r_has_tok;
    logic                   n_has_tok;
    logic                   r_chan;
    logic                   n_chan;
    logic                   r_drop;
    logic                   n_drop;
    logic                   r_loop;
    logic                   n_loop;
    logic                   r_comma;
    logic                   n_comma;

    // Shared signals.
    logic                   accept;
    logic                   lw_on;
    logic [COLUMN_BITS-1:0] lw_ext;
    logic [BYTE_W-1:0]      zw_eff;
    logic                   rem_start;
    logic                   rem_busy;
    logic [BYTE_W-1:0]      rem_val;
    t_tok_req               tok_req;
    logic                   tok_taken;

    // Decode of an incoming word.
    logic                   in_drop;
    logic [BYTE_W-1:0]      want;
    logic [COLUMN_BITS:0]   fit_sum;
    logic                   dec_crlf;
    logic                   dec_tok;
    logic                   dec_space;
    logic                   dec_rem;
    logic [BYTE_W-1:0]      dec_ch;
    logic [BYTE_W-1:0]      dec_cnt;
    logic                   dec_adv;
    logic                   dec_col_set;
    logic [COLUMN_BITS-1:0] dec_col;

    // Space chunk step.
    logic                   sp_wrap;
    logic [COLUMN_BITS-1:0] sp_wdist;
    logic [COLUMN_BITS:0]   sp_odist;
    logic [BYTE_W-1:0]      sp_zdist;
    logic [COLUMN_BITS:0]   sp_kw;
    logic [BYTE_W-1:0]      sp_k;
    logic [COLUMN_BITS:0]   sp_sum;
    logic [BYTE_W:0]        sp_rsum;
    logic [BYTE_W-1:0]      sp_rem;
    logic                   sp_last;

    assign accept = i_in.valid && i_in.ready;
    assign lw_on  = (r_line_width != '0);
    assign lw_ext = COLUMN_BITS'(r_line_width);
    assign zw_eff = (r_zone_width == '0) ? BYTE_W'(1) : r_zone_width;

    // Configuration writes; a small nonzero line width is raised to the minimum.
    always_comb begin
        n_line_width = r_line_width;
        n_zone_width = r_zone_width;
        n_last_zone  = r_last_zone;
        if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_LINE_WIDTH: begin
                    if ((i_cfg_data != '0) && (i_cfg_data < LINE_WIDTH_MIN)) begin
                        n_line_width = LINE_WIDTH_MIN;
                    end else begin
                        n_line_width = i_cfg_data;
                    end
                end
                CFG_ZONE_WIDTH: n_zone_width = i_cfg_data;
                CFG_LAST_ZONE:  n_last_zone  = i_cfg_data;
                default: ;
            endcase
        end
    end

    // Decode of the input word against the current column.
    always_comb begin
        in_drop     = i_in.quiet || i_in.error_pending;
        want        = (lw_on && (i_in.value > r_line_width)) ? r_line_width : i_in.value;
        fit_sum     = {1'b0, r_col} + (COLUMN_BITS + 1)'(i_in.value);
        dec_crlf    = 1'b0;
        dec_tok     = 1'b0;
        dec_space   = 1'b0;
        dec_rem     = 1'b0;
        dec_ch      = CH_SPACE;
        dec_cnt     = BYTE_W'(1);
        dec_adv     = 1'b0;
        dec_col_set = 1'b0;
        dec_col     = '0;
        case (i_in.action)
            ACT_CHAR: begin
                dec_ch = i_in.value;
                if (!in_drop) begin
                    dec_tok = 1'b1;
                    if (!i_in.to_channel) begin
                        dec_adv  = (i_in.value >= CH_SPACE);
                        dec_crlf = (i_in.value >= CH_SPACE) && lw_on && (r_col == lw_ext);
                    end
                end
                // A carriage return always puts the column back to zero.
                if (i_in.value == CH_CR) begin
                    dec_col_set = 1'b1;
                end
            end
            ACT_TAB: begin
                dec_cnt = want - r_col[BYTE_W-1:0];
                if (!in_drop && (r_col < COLUMN_BITS'(want))) begin
                    dec_tok = 1'b1;
                    if (!i_in.to_channel) begin
                        dec_col_set = 1'b1;
                        dec_col     = COLUMN_BITS'(want);
                    end
                end
            end
            ACT_SKIP: begin
                dec_cnt = i_in.value;
                if (!in_drop && (i_in.value != '0)) begin
                    if (i_in.to_channel) begin
                        dec_tok = 1'b1;
                    end else begin
                        dec_space = 1'b1;
                    end
                end
            end
            ACT_COMMA: begin
                if (r_col >= COLUMN_BITS'(r_last_zone)) begin
                    dec_crlf = !i_in.error_pending;
                end else begin
                    dec_rem = 1'b1;
                end
            end
            ACT_NEWLINE: begin
                dec_crlf = !i_in.error_pending;
            end
            ACT_FIT: begin
                dec_crlf = lw_on && (fit_sum > (COLUMN_BITS + 1)'(r_line_width))
                           && !i_in.error_pending;
            end
            default: ;
        endcase
    end

    // Next space chunk: stops at the remaining count, the wrap column,
    // the column rollover and, for a comma, the zone boundary.
    always_comb begin
        sp_wrap  = lw_on && (r_col == lw_ext);
        sp_wdist = lw_ext - r_col;
        sp_odist = {1'b1, {COLUMN_BITS{1'b0}}} - {1'b0, r_col};
        sp_zdist = zw_eff - r_rem;
        sp_kw    = (COLUMN_BITS + 1)'(r_left);
        if (lw_on && (r_col < lw_ext) && ((COLUMN_BITS + 1)'(sp_wdist) < sp_kw)) begin
            sp_kw = (COLUMN_BITS + 1)'(sp_wdist);
        end
        if (sp_odist < sp_kw) begin
            sp_kw = sp_odist;
        end
        if (r_comma && ((COLUMN_BITS + 1)'(sp_zdist) < sp_kw)) begin
            sp_kw = (COLUMN_BITS + 1)'(sp_zdist);
        end
        sp_k    = sp_kw[BYTE_W-1:0];
        sp_sum  = {1'b0, r_col} + (COLUMN_BITS + 1)'(sp_k);
        sp_rsum = {1'b0, r_rem} + {1'b0, sp_k};
        if (sp_sum[COLUMN_BITS] || (sp_rsum == {1'b0, zw_eff})) begin
            sp_rem = '0;
        end else begin
            sp_rem = sp_rsum[BYTE_W-1:0];
        end
        sp_last = (r_left == sp_k) || (r_comma && (sp_rem == '0));
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    if (dec_rem) begin
                        n_state = ST_REM;
                    end else if (dec_crlf) begin
                        n_state = ST_CR;
                    end else if (dec_space) begin
                        n_state = ST_SPACE;
                    end else if (dec_tok) begin
                        n_state = ST_TOK;
                    end
                end
            end
            ST_REM: begin
                if (!rem_busy) begin
                    if (r_drop) begin
                        n_state = ST_IDLE;
                    end else if (r_chan) begin
                        n_state = ST_TOK;
                    end else begin
                        n_state = ST_SPACE;
                    end
                end
            end
            ST_CR: begin
                if (tok_taken) begin
                    n_state = ST_LF;
                end
            end
            ST_LF: begin
                if (tok_taken) begin
                    if (r_loop) begin
                        n_state = ST_SPACE;
                    end else if (r_has_tok) begin
                        n_state = ST_TOK;
                    end else begin
                        n_state = ST_FLUSH;
                    end
                end
            end
            ST_TOK: begin
                if (tok_taken) begin
                    n_state = ST_FLUSH;
                end
            end
            ST_SPACE: begin
                if (sp_wrap) begin
                    n_state = ST_CR;
                end else if (tok_taken && sp_last) begin
                    n_state = ST_FLUSH;
                end
            end
            ST_FLUSH: begin
                if (tok_taken) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Sequencer outputs.
    always_comb begin
        i_in.ready    = (r_state == ST_IDLE);
        rem_start     = 1'b0;
        tok_req.valid = 1'b0;
        tok_req.flush = 1'b0;
        tok_req.ch    = CH_SPACE;
        tok_req.cnt   = BYTE_W'(1);
        tok_req.chan  = r_chan;
        case (r_state)
            ST_IDLE: begin
                rem_start = accept && dec_rem;
            end
            ST_CR: begin
                tok_req.valid = 1'b1;
                tok_req.ch    = CH_CR;
            end
            ST_LF: begin
                tok_req.valid = 1'b1;
                tok_req.ch    = CH_LF;
            end
            ST_TOK: begin
                tok_req.valid = 1'b1;
                tok_req.ch    = r_tok_ch;
                tok_req.cnt   = r_tok_cnt;
            end
            ST_SPACE: begin
                tok_req.valid = !sp_wrap;
                tok_req.cnt   = sp_k;
                tok_req.chan  = 1'b0;
            end
            ST_FLUSH: begin
                tok_req.flush = 1'b1;
            end
            default: ;
        endcase
    end

    // Datapath updates.
    always_comb begin
        n_col     = r_col;
        n_rem     = r_rem;
        n_left    = r_left;
        n_tok_ch  = r_tok_ch;
        n_tok_cnt = r_tok_cnt;
        n_tok_adv = r_tok_adv;
        n_has_tok = r_has_tok;
        n_chan    = r_chan;
        n_drop    = r_drop;
        n_loop    = r_loop;
        n_comma   = r_comma;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_tok_ch  = dec_ch;
                    n_tok_cnt = dec_cnt;
                    n_tok_adv = dec_adv;
                    n_has_tok = dec_tok;
                    n_chan    = i_in.to_channel;
                    n_drop    = in_drop;
                    n_loop    = dec_space;
                    n_comma   = 1'b0;
                    n_left    = i_in.value;
                    if (dec_col_set) begin
                        n_col = dec_col;
                    end
                end
            end
            ST_REM: begin
                if (!rem_busy) begin
                    n_rem     = rem_val;
                    n_tok_ch  = CH_SPACE;
                    n_tok_cnt = zw_eff - rem_val;
                    n_tok_adv = 1'b0;
                    n_left    = '1;
                    n_comma   = 1'b1;
                    n_loop    = 1'b1;
                end
            end
            ST_LF: begin
                if (tok_taken && !r_chan) begin
                    n_col = '0;
                    n_rem = '0;
                end
            end
            ST_TOK: begin
                if (tok_taken && r_tok_adv) begin
                    n_col = r_col + 1'b1;
                end
            end
            ST_SPACE: begin
                if (!sp_wrap && tok_taken) begin
                    n_col  = sp_sum[COLUMN_BITS-1:0];
                    n_rem  = sp_rem;
                    n_left = r_left - sp_k;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_col        <= '0;
            r_line_width <= LINE_WIDTH_RST;
            r_zone_width <= ZONE_WIDTH_RST;
            r_last_zone  <= LAST_ZONE_RST;
        end else begin
            r_state      <= n_state;
            r_col        <= n_col;
            r_line_width <= n_line_width;
            r_zone_width <= n_zone_width;
            r_last_zone  <= n_last_zone;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem     <= n_rem;
        r_left    <= n_left;
        r_tok_ch  <= n_tok_ch;
        r_tok_cnt <= n_tok_cnt;
        r_tok_adv <= n_tok_adv;
        r_has_tok <= n_has_tok;
        r_chan    <= n_chan;
        r_drop    <= n_drop;
        r_loop    <= n_loop;
        r_comma   <= n_comma;
    end

    // Column modulo zone width.
    tct_rem_unit #(
        .COLUMN_BITS (COLUMN_BITS)
    ) u_rem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (rem_start),
        .i_dividend (r_col),
        .i_divisor  (zw_eff),
        .o_busy     (rem_busy),
        .o_rem      (rem_val)
    );

    // Run merging and output register.
    tct_packer u_packer (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (tok_req),
        .o_taken (tok_taken),
        .o_out   (o_out)
    );

endmodule
